@@ sv/double_ended_queue_unit_macros.svh @@
// assertion macros for the double-ended queue unit
// no dependencies; included by files that check their own logic
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked only while out of reset
`define DEQ_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("deque check failed");
// checked at every edge, reset included
`define DEQ_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("deque check failed");
`else
`define DEQ_ASSERT(name, clk, rstn, prop)
`define DEQ_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

@@ sv/deq_pkg.sv @@
// shared types, constants and ring-index helpers for the double-ended queue
// no dependencies
package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int PORT_W     = 32;
    localparam int TOTAL_W    = 5;
    localparam int REQ_W      = 3;
    localparam int ERR_W      = 2;

    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [DATA_WIDTH-1:0] word_t;
    typedef logic [PORT_W-1:0]     port_word_t;

    localparam cnt_t CNT_FULL = cnt_t'(DEPTH);

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_PEEK       = 3'd4
    } req_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE  = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } err_t;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    // (idx + off) mod DEPTH, the sum stays below twice the depth
    function automatic idx_t ring_add(idx_t idx, cnt_t off);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(idx) + (CNT_W+1)'(off);
        if (s >= (CNT_W+1)'(DEPTH)) begin
            s = s - (CNT_W+1)'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    function automatic idx_t ring_inc(idx_t idx);
        return (idx == idx_t'(DEPTH - 1)) ? '0 : idx_t'(idx + 1'b1);
    endfunction

    function automatic idx_t ring_dec(idx_t idx);
        return (idx == '0) ? idx_t'(DEPTH - 1) : idx_t'(idx - 1'b1);
    endfunction

    function automatic word_t fit_word(port_word_t v);
        word_t r;
        r = '0;
        for (int i = 0; i < DATA_WIDTH && i < PORT_W; i++) begin
            r[i] = v[i];
        end
        return r;
    endfunction

    function automatic port_word_t to_port(word_t v);
        port_word_t r;
        r = '0;
        for (int i = 0; i < DATA_WIDTH && i < PORT_W; i++) begin
            r[i] = v[i];
        end
        return r;
    endfunction

endpackage

@@ sv/deq_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/double_ended_queue_unit.sv @@
// Bounded double-ended queue of DEPTH words held in a ring inside one ram.
// Front and back words are kept in registers beside the ram, so a push, a
// peek or a rejected request answers in the cycle after it is accepted; a
// successful pop first waits in ST_READ for the registered ram read of the
// new front or back word, then its result is registered. A new request is
// taken when the previous result has been delivered or is being delivered
// in the same cycle, and not in ST_READ. Errors (push when full, pop when
// empty) leave the queue unchanged; front and back read as zero when empty.
// Depends on deq_pkg, deq_ram and double_ended_queue_unit_macros.svh.
`include "double_ended_queue_unit_macros.svh"

module double_ended_queue_unit
    import deq_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [REQ_W-1:0]   s_req_type,
    input  logic [PORT_W-1:0]  s_data_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [PORT_W-1:0]  m_popped_value,
    output logic [PORT_W-1:0]  m_front_value,
    output logic [PORT_W-1:0]  m_back_value,
    output logic [TOTAL_W-1:0] m_entry_total,
    output logic               m_is_empty,
    output logic               m_is_full,
    output logic [ERR_W-1:0]   m_op_error
);

    state_t state_reg, state_next;
    idx_t   front_idx_reg, front_idx_next;
    cnt_t   count_reg, count_next;
    word_t  front_word_reg, front_word_next;
    word_t  back_word_reg, back_word_next;
    word_t  popped_reg, popped_next;
    logic   from_front_reg, from_front_next;

    logic         m_valid_reg, m_valid_next;
    port_word_t   m_popped_reg, m_popped_next;
    port_word_t   m_front_reg, m_front_next;
    port_word_t   m_back_reg, m_back_next;
    cnt_t         m_total_reg, m_total_next;
    err_t         m_err_reg, m_err_next;

    logic  ram_we, ram_re;
    idx_t  ram_waddr, ram_raddr;
    word_t ram_wdata, ram_rdata;

    logic  accept, out_free, is_pop, start_read;
    req_t  req;
    word_t in_word;
    err_t  err;
    cnt_t  pop_off;

    deq_ram #(
        .WIDTH(DATA_WIDTH),
        .DEPTH(DEPTH)
    ) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign req      = req_t'(s_req_type);
    assign in_word  = fit_word(s_data_value);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign is_pop   = (req == REQ_POP_FRONT) || (req == REQ_POP_BACK);
    assign start_read = accept && is_pop && (count_reg != '0);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start_read) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and result register
    always_comb begin
        front_idx_next  = front_idx_reg;
        count_next      = count_reg;
        front_word_next = front_word_reg;
        back_word_next  = back_word_reg;
        popped_next     = popped_reg;
        from_front_next = from_front_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_popped_next   = m_popped_reg;
        m_front_next    = m_front_reg;
        m_back_next     = m_back_reg;
        m_total_next    = m_total_reg;
        m_err_next      = m_err_reg;
        ram_we          = 1'b0;
        ram_waddr       = ring_add(front_idx_reg, count_reg);
        ram_wdata       = in_word;
        ram_re          = 1'b0;
        ram_raddr       = ring_inc(front_idx_reg);
        err             = ERR_NONE;
        pop_off         = '0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (req)
                        REQ_PUSH_FRONT: begin
                            if (count_reg == CNT_FULL) begin
                                err = ERR_FULL;
                            end else begin
                                front_idx_next  = ring_dec(front_idx_reg);
                                ram_we          = 1'b1;
                                ram_waddr       = ring_dec(front_idx_reg);
                                front_word_next = in_word;
                                if (count_reg == '0) begin
                                    back_word_next = in_word;
                                end
                                count_next = cnt_t'(count_reg + 1'b1);
                            end
                        end
                        REQ_PUSH_BACK: begin
                            if (count_reg == CNT_FULL) begin
                                err = ERR_FULL;
                            end else begin
                                ram_we         = 1'b1;
                                back_word_next = in_word;
                                if (count_reg == '0) begin
                                    front_word_next = in_word;
                                end
                                count_next = cnt_t'(count_reg + 1'b1);
                            end
                        end
                        REQ_POP_FRONT: begin
                            if (count_reg == '0) begin
                                err = ERR_EMPTY;
                            end else begin
                                popped_next     = front_word_reg;
                                from_front_next = 1'b1;
                                front_idx_next  = ring_inc(front_idx_reg);
                                count_next      = cnt_t'(count_reg - 1'b1);
                                ram_re          = 1'b1;
                            end
                        end
                        REQ_POP_BACK: begin
                            if (count_reg == '0) begin
                                err = ERR_EMPTY;
                            end else begin
                                popped_next     = back_word_reg;
                                from_front_next = 1'b0;
                                count_next      = cnt_t'(count_reg - 1'b1);
                                // new back sits at offset count - 2
                                if (count_reg > cnt_t'(1)) begin
                                    pop_off = cnt_t'(count_reg - 2'd2);
                                end
                                ram_re    = 1'b1;
                                ram_raddr = ring_add(front_idx_reg, pop_off);
                            end
                        end
                        default: begin
                            err = ERR_NONE;
                        end
                    endcase

                    // everything but a successful pop answers right away
                    if (!start_read) begin
                        m_valid_next  = 1'b1;
                        m_popped_next = '0;
                        m_front_next  = (count_next != '0) ? to_port(front_word_next) : '0;
                        m_back_next   = (count_next != '0) ? to_port(back_word_next) : '0;
                        m_total_next  = count_next;
                        m_err_next    = err;
                    end
                end
            end
            ST_READ: begin
                if (out_free) begin
                    if (from_front_reg) begin
                        front_word_next = ram_rdata;
                    end else begin
                        back_word_next = ram_rdata;
                    end
                    m_valid_next  = 1'b1;
                    m_popped_next = to_port(popped_reg);
                    m_front_next  = (count_reg != '0) ? to_port(front_word_next) : '0;
                    m_back_next   = (count_reg != '0) ? to_port(back_word_next) : '0;
                    m_total_next  = count_reg;
                    m_err_next    = ERR_NONE;
                end
            end
            default: begin
                m_err_next = ERR_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            front_idx_reg <= '0;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            front_idx_reg <= front_idx_next;
            count_reg     <= count_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        front_word_reg <= front_word_next;
        back_word_reg  <= back_word_next;
        popped_reg     <= popped_next;
        from_front_reg <= from_front_next;
        m_popped_reg   <= m_popped_next;
        m_front_reg    <= m_front_next;
        m_back_reg     <= m_back_next;
        m_total_reg    <= m_total_next;
        m_err_reg      <= m_err_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_popped_value = m_popped_reg;
    assign m_front_value  = m_front_reg;
    assign m_back_value   = m_back_reg;
    assign m_entry_total  = TOTAL_W'(m_total_reg);
    assign m_is_empty     = (m_total_reg == '0);
    assign m_is_full      = (m_total_reg == CNT_FULL);
    assign m_op_error     = m_err_reg;

    `DEQ_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_FULL)
    `DEQ_ASSERT(a_pop_reads, aclk, aresetn, start_read |=> state_reg == ST_READ)
    `DEQ_ASSERT(a_read_no_request, aclk, aresetn, state_reg == ST_READ |-> !accept)
    `DEQ_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> count_reg == '0 && !m_valid_reg)

endmodule
